/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int DATA_W   = 16;
    localparam int SQ_SHIFT = 30;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
    } quat_t;

    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } comp_t;

endpackage

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix in signed fixed point to a unit quaternion.
//
//   Channel   Signals                        Payload
//   matrix    mat_valid / mat_ready          mat  (mat_t, nine entries)
//   result    quat_valid / quat_ready        quat (quat_t, w x y z)
//
// One matrix enters per cycle unless the result is stalled. The data passes
// through the two bit-per-stage square root pipelines (the first gives
// 24-bit roots at the default) and the bit-per-stage divider. Reset
// clears only the valid bits. A stalled result freezes the whole pipeline;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  mat_valid,
    output logic  mat_ready,
    input  mat_t  mat,
    output logic  quat_valid,
    input  logic  quat_ready,
    output quat_t quat
);

    localparam int S_W    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int T_W    = S_W - 1;
    localparam int RAD_W  = T_W + SQ_SHIFT;
    localparam int A_W    = (RAD_W + 1) / 2;
    localparam int SQ_W   = 2 * A_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int N_W    = (SUM_W + 1) / 2;
    localparam int NUM_W  = A_W + FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int SIDE2  = 4 * A_W + 4;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    logic en;
    assign en        = !quat_valid || quat_ready;
    assign mat_ready = en;

    // Stage 1: candidate squares and sign tests.
    logic                    v1_reg;
    logic [3:0][T_W-1:0]     t_reg;
    logic [5:0]              pos_reg;
    logic signed [S_W-1:0]   s_next [4];
    logic [3:0][T_W-1:0]     t_next;
    logic [5:0]              pos_next;

    always_comb
    begin
        logic signed [S_W-1:0] e00;
        logic signed [S_W-1:0] e11;
        logic signed [S_W-1:0] e22;
        logic signed [S_W-1:0] one_s;
        logic signed [16:0]    d;
        e00   = S_W'(mat.m00);
        e11   = S_W'(mat.m11);
        e22   = S_W'(mat.m22);
        one_s = S_W'(ONE_L);
        s_next[0] =  e00 + e11 + e22 + one_s;
        s_next[1] =  e00 - e11 - e22 + one_s;
        s_next[2] = -e00 + e11 - e22 + one_s;
        s_next[3] = -e00 - e11 + e22 + one_s;
        for (int i = 0; i < 4; i++)
        begin
            t_next[i] = s_next[i][S_W-1] ? '0 : s_next[i][T_W-1:0];
        end
        d = 17'(mat.m21) - 17'(mat.m12);
        pos_next[0] = !d[16];
        d = 17'(mat.m02) - 17'(mat.m20);
        pos_next[1] = !d[16];
        d = 17'(mat.m10) - 17'(mat.m01);
        pos_next[2] = !d[16];
        d = 17'(mat.m10) + 17'(mat.m01);
        pos_next[3] = !d[16];
        d = 17'(mat.m02) + 17'(mat.m20);
        pos_next[4] = !d[16];
        d = 17'(mat.m21) + 17'(mat.m12);
        pos_next[5] = !d[16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= mat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_next;
            pos_reg <= pos_next;
        end
    end

    // Component magnitudes.
    logic [3:0][RAD_W-1:0] rad1;
    logic                  v2;
    logic [3:0][A_W-1:0]   a2;
    logic [5:0]            pos2;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rad1[i] = {t_reg[i], {SQ_SHIFT{1'b0}}};
        end
    end

    rmq_isqrt #(
        .LANES  (4),
        .RAD_W  (RAD_W),
        .SIDE_W (6)
    ) u_sqrt_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_rad    (rad1),
        .in_side   (pos_reg),
        .out_valid (v2),
        .out_root  (a2),
        .out_side  (pos2)
    );

    // Stage 3: reference choice, signs and squares.
    logic                v3_reg;
    logic [3:0][A_W-1:0] a3_reg;
    logic [3:0][SQ_W-1:0] sq3_reg;
    logic [3:0]          neg3_reg;
    comp_t               best;
    logic [3:0]          neg_next;

    always_comb
    begin
        best = COMP_W;
        if (a2[1] > a2[best])
        begin
            best = COMP_X;
        end
        if (a2[2] > a2[best])
        begin
            best = COMP_Y;
        end
        if (a2[3] > a2[best])
        begin
            best = COMP_Z;
        end
        case (best)
            COMP_W:  neg_next = {!pos2[2], !pos2[1], !pos2[0], 1'b0};
            COMP_X:  neg_next = {!pos2[4], !pos2[3], 1'b0, !pos2[0]};
            COMP_Y:  neg_next = {!pos2[5], 1'b0, !pos2[3], !pos2[1]};
            COMP_Z:  neg_next = {1'b0, !pos2[5], !pos2[4], !pos2[2]};
            default: neg_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg   <= a2;
            neg3_reg <= neg_next;
            for (int i = 0; i < 4; i++)
            begin
                sq3_reg[i] <= SQ_W'(a2[i]) * SQ_W'(a2[i]);
            end
        end
    end

    // Stages 4 and 5: sum of squares.
    logic                  v4_reg;
    logic [SQ_W:0]         p01_reg;
    logic [SQ_W:0]         p23_reg;
    logic [3:0][A_W-1:0]   a4_reg;
    logic [3:0]            neg4_reg;
    logic                  v5_reg;
    logic [SUM_W-1:0]      sum5_reg;
    logic [3:0][A_W-1:0]   a5_reg;
    logic [3:0]            neg5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p01_reg  <= (SQ_W+1)'(sq3_reg[0]) + (SQ_W+1)'(sq3_reg[1]);
            p23_reg  <= (SQ_W+1)'(sq3_reg[2]) + (SQ_W+1)'(sq3_reg[3]);
            a4_reg   <= a3_reg;
            neg4_reg <= neg3_reg;
            sum5_reg <= SUM_W'(p01_reg) + SUM_W'(p23_reg);
            a5_reg   <= a4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Norm.
    logic [0:0][SUM_W-1:0] rad2;
    logic                  v6;
    logic [0:0][N_W-1:0]   n6;
    logic [SIDE2-1:0]      side6;
    logic [3:0][A_W-1:0]   a6;
    logic [3:0]            neg6;

    assign rad2[0] = sum5_reg;
    assign {a6, neg6} = side6;

    rmq_isqrt #(
        .LANES  (1),
        .RAD_W  (SUM_W),
        .SIDE_W (SIDE2)
    ) u_sqrt_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_rad    (rad2),
        .in_side   ({a5_reg, neg5_reg}),
        .out_valid (v6),
        .out_root  (n6),
        .out_side  (side6)
    );

    // Stage 7: rounded numerators.
    logic                  v7_reg;
    logic [3:0][NUM_W-1:0] num7_reg;
    logic [N_W-1:0]        n7_reg;
    logic [3:0]            neg7_reg;
    logic                  nz7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= v6;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                num7_reg[i] <= (NUM_W'(a6[i]) << FRAC_BITS) + NUM_W'(n6[0] >> 1);
            end
            n7_reg   <= n6[0];
            neg7_reg <= neg6;
            nz7_reg  <= (n6[0] == '0);
        end
    end

    // Division by the norm.
    logic                v8;
    logic [3:0][Q_W-1:0] q8;
    logic [4:0]          side8;

    rmq_div #(
        .LANES  (4),
        .NUM_W  (NUM_W),
        .DEN_W  (N_W),
        .Q_W    (Q_W),
        .SIDE_W (5)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_num    (num7_reg),
        .in_den    (n7_reg),
        .in_side   ({nz7_reg, neg7_reg}),
        .out_valid (v8),
        .out_quo   (q8),
        .out_side  (side8)
    );

    // Output stage: clamp, sign and narrow to the field width; a zero norm gives the identity quaternion.
    logic                     out_v_reg;
    quat_t                    out_reg;
    logic [3:0][DATA_W-1:0]   res_next;

    always_comb
    begin
        logic [Q_W-1:0]    qc;
        logic [DATA_W-1:0] q16;
        for (int i = 0; i < 4; i++)
        begin
            qc  = (q8[i] > Q_W'(ONE_L)) ? Q_W'(ONE_L) : q8[i];
            q16 = DATA_W'(qc);
            if (side8[4])
            begin
                res_next[i] = (i == 0) ? DATA_W'(ONE_L) : '0;
            end
            else if (side8[i])
            begin
                res_next[i] = -q16;
            end
            else
            begin
                res_next[i] = q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= v8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.quat_w <= res_next[0];
            out_reg.quat_x <= res_next[1];
            out_reg.quat_y <= res_next[2];
            out_reg.quat_z <= res_next[3];
        end
    end

    assign quat_valid = out_v_reg;
    assign quat       = out_reg;

    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (quat_valid && !quat_ready) |-> !mat_ready
    ) else $error("matrix accepted while the result is stalled");

    a_one_positive: assert property (
        @(posedge clk) disable iff (!rst_n)
        v3_reg |-> !(neg3_reg[0] && neg3_reg[1] && neg3_reg[2] && neg3_reg[3])
    ) else $error("reference component carries a negative sign");

    a_quotient_fits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v7_reg && !nz7_reg) |->
            ((num7_reg[0] >> Q_W) < NUM_W'(n7_reg)) &&
            ((num7_reg[1] >> Q_W) < NUM_W'(n7_reg)) &&
            ((num7_reg[2] >> Q_W) < NUM_W'(n7_reg)) &&
            ((num7_reg[3] >> Q_W) < NUM_W'(n7_reg))
    ) else $error("numerator exceeds the divider quotient range");

    a_norm_not_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        v7_reg |-> !nz7_reg
    ) else $error("zero norm reached the divider");

endmodule

/* rtl/rmq_isqrt.sv */
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one root bit per stage, several lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_isqrt
    import rmq_pkg::*;
#(
    parameter int LANES  = 4,
    parameter int RAD_W  = 48,
    parameter int SIDE_W = 6
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [LANES-1:0][RAD_W-1:0]           in_rad,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic [LANES-1:0][(RAD_W+1)/2-1:0]     out_root,
    output logic [SIDE_W-1:0]                     out_side
);

    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    logic [LANES-1:0][REM_W-1:0]  rem_reg  [ROOT_W];
    logic [LANES-1:0][ROOT_W-1:0] root_reg [ROOT_W];
    logic [LANES-1:0][PAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0]            side_reg [ROOT_W];
    logic [ROOT_W-1:0]            vld_reg;

    logic [LANES-1:0][REM_W-1:0]  rem_prev  [ROOT_W];
    logic [LANES-1:0][ROOT_W-1:0] root_prev [ROOT_W];
    logic [LANES-1:0][PAD_W-1:0]  rad_prev  [ROOT_W];
    logic [SIDE_W-1:0]            side_prev [ROOT_W];
    logic [ROOT_W-1:0]            vld_prev;

    logic [LANES-1:0][REM_W-1:0]  rem_next  [ROOT_W];
    logic [LANES-1:0][ROOT_W-1:0] root_next [ROOT_W];
    logic [LANES-1:0][PAD_W-1:0]  rad_next  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_prev[0][l]  = '0;
                        root_prev[0][l] = '0;
                        rad_prev[0][l]  = PAD_W'(in_rad[l]);
                    end
                end
                assign side_prev[0] = in_side;
                assign vld_prev[0]  = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev[k]  = rem_reg[k-1];
                assign root_prev[k] = root_reg[k-1];
                assign rad_prev[k]  = rad_reg[k-1];
                assign side_prev[k] = side_reg[k-1];
                assign vld_prev[k]  = vld_reg[k-1];
            end

            always_comb
            begin
                logic [REM_W-1:0] rem_sh;
                logic [REM_W-1:0] trial;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_sh = {rem_prev[k][l][REM_W-3:0], rad_prev[k][l][PAD_W-1 -: 2]};
                    trial  = REM_W'({root_prev[k][l], 2'b01});
                    if (rem_sh >= trial)
                    begin
                        rem_next[k][l]  = rem_sh - trial;
                        root_next[k][l] = {root_prev[k][l][ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k][l]  = rem_sh;
                        root_next[k][l] = {root_prev[k][l][ROOT_W-2:0], 1'b0};
                    end
                    rad_next[k][l] = rad_prev[k][l] << 2;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next[k];
                    root_reg[k] <= root_next[k];
                    rad_reg[k]  <= rad_next[k];
                    side_reg[k] <= side_prev[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* rtl/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_div
    import rmq_pkg::*;
#(
    parameter int LANES  = 4,
    parameter int NUM_W  = 39,
    parameter int DEN_W  = 25,
    parameter int Q_W    = 15,
    parameter int SIDE_W = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   in_num,
    input  logic [DEN_W-1:0]              in_den,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [LANES-1:0][Q_W-1:0]     out_quo,
    output logic [SIDE_W-1:0]             out_side
);

    logic [LANES-1:0][DEN_W-1:0] rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   lo_reg   [Q_W];
    logic [LANES-1:0][Q_W-1:0]   quo_reg  [Q_W];
    logic [DEN_W-1:0]            den_reg  [Q_W];
    logic [SIDE_W-1:0]           side_reg [Q_W];
    logic [Q_W-1:0]              vld_reg;

    logic [LANES-1:0][DEN_W-1:0] rem_prev  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   lo_prev   [Q_W];
    logic [LANES-1:0][Q_W-1:0]   quo_prev  [Q_W];
    logic [DEN_W-1:0]            den_prev  [Q_W];
    logic [SIDE_W-1:0]           side_prev [Q_W];
    logic [Q_W-1:0]              vld_prev;

    logic [LANES-1:0][DEN_W-1:0] rem_next [Q_W];
    logic [LANES-1:0][Q_W-1:0]   lo_next  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   quo_next [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_prev[0][l] = DEN_W'(in_num[l] >> Q_W);
                        lo_prev[0][l]  = in_num[l][Q_W-1:0];
                        quo_prev[0][l] = '0;
                    end
                end
                assign den_prev[0]  = in_den;
                assign side_prev[0] = in_side;
                assign vld_prev[0]  = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev[k]  = rem_reg[k-1];
                assign lo_prev[k]   = lo_reg[k-1];
                assign quo_prev[k]  = quo_reg[k-1];
                assign den_prev[k]  = den_reg[k-1];
                assign side_prev[k] = side_reg[k-1];
                assign vld_prev[k]  = vld_reg[k-1];
            end

            always_comb
            begin
                logic [DEN_W:0] rem_sh;
                logic [DEN_W:0] den_ext;
                logic [DEN_W:0] diff;
                den_ext = {1'b0, den_prev[k]};
                for (int l = 0; l < LANES; l++)
                begin
                    rem_sh = {rem_prev[k][l], lo_prev[k][l][Q_W-1]};
                    diff   = rem_sh - den_ext;
                    if (rem_sh >= den_ext)
                    begin
                        rem_next[k][l] = diff[DEN_W-1:0];
                        quo_next[k][l] = {quo_prev[k][l][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k][l] = rem_sh[DEN_W-1:0];
                        quo_next[k][l] = {quo_prev[k][l][Q_W-2:0], 1'b0};
                    end
                    lo_next[k][l] = lo_prev[k][l] << 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next[k];
                    lo_reg[k]   <= lo_next[k];
                    quo_reg[k]  <= quo_next[k];
                    den_reg[k]  <= den_prev[k];
                    side_reg[k] <= side_prev[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

/* verif/rotation_matrix_to_quaternion_unit_tb.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// Self-checking bench for the matrix to quaternion converter. Directed
// matrices (identity, half turns, extreme entries, ties, sign edge cases)
// are followed by random rotations and raw bit patterns. Each result is
// checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit_tb;
    import rmq_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int LATENCY = 2 * 24 + FRAC_BITS + 8;
    localparam int N_RANDOM = 1330;
    localparam longint CYCLE_LIMIT = 400000;

    class quat_scoreboard;
        quat_t expected_q[$];
        int errors;
        int checked;

        function longint unsigned root64(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function longint unsigned magnitude(longint s);
            longint unsigned t;
            t = (s > 0) ? longint'(s) : 0;
            return root64(t << SQ_SHIFT);
        endfunction

        function int dir(longint v);
            return (v >= 0) ? 1 : -1;
        endfunction

        function quat_t convert(mat_t m);
            longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
            longint unsigned mag[4];
            int sg[4];
            longint unsigned sq, n, q;
            longint v;
            comp_t lead;
            logic [15:0] r[4];
            quat_t res;
            a00 = m.m00; a01 = m.m01; a02 = m.m02;
            a10 = m.m10; a11 = m.m11; a12 = m.m12;
            a20 = m.m20; a21 = m.m21; a22 = m.m22;
            mag[0] = magnitude(a00 + a11 + a22 + ONE);
            mag[1] = magnitude(a00 - a11 - a22 + ONE);
            mag[2] = magnitude(-a00 + a11 - a22 + ONE);
            mag[3] = magnitude(-a00 - a11 + a22 + ONE);
            lead = COMP_W;
            for (int i = 1; i < 4; i++)
                if (mag[i] > mag[lead])
                    lead = comp_t'(i);
            case (lead)
                COMP_W:
                begin
                    sg[0] = 1; sg[1] = dir(a21 - a12);
                    sg[2] = dir(a02 - a20); sg[3] = dir(a10 - a01);
                end
                COMP_X:
                begin
                    sg[0] = dir(a21 - a12); sg[1] = 1;
                    sg[2] = dir(a10 + a01); sg[3] = dir(a02 + a20);
                end
                COMP_Y:
                begin
                    sg[0] = dir(a02 - a20); sg[1] = dir(a10 + a01);
                    sg[2] = 1; sg[3] = dir(a21 + a12);
                end
                default:
                begin
                    sg[0] = dir(a10 - a01); sg[1] = dir(a20 + a02);
                    sg[2] = dir(a21 + a12); sg[3] = 1;
                end
            endcase
            sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2] + mag[3] * mag[3];
            n = root64(sq);
            for (int i = 0; i < 4; i++)
            begin
                if (n == 0)
                    v = (i == 0) ? ONE : 0;
                else
                begin
                    q = (mag[i] * ONE + (n >> 1)) / n;
                    if (q > ONE)
                        q = ONE;
                    v = longint'(q) * sg[i];
                end
                r[i] = v[15:0];
            end
            res.quat_w = r[0]; res.quat_x = r[1]; res.quat_y = r[2]; res.quat_z = r[3];
            return res;
        endfunction

        function void note_matrix(mat_t m);
            expected_q = {expected_q, convert(m)};
        endfunction

        function void check_quat(quat_t got);
            quat_t exp_q;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_q = expected_q.pop_front();
            checked++;
            if (got.quat_w !== exp_q.quat_w)
                $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.quat_w, got.quat_w);
            if (got.quat_x !== exp_q.quat_x)
                $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.quat_x, got.quat_x);
            if (got.quat_y !== exp_q.quat_y)
                $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.quat_y, got.quat_y);
            if (got.quat_z !== exp_q.quat_z)
                $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.quat_z, got.quat_z);
            if (got !== exp_q)
                errors++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic mat_valid = 1'b0;
    logic mat_ready;
    mat_t mat = '0;
    logic quat_valid;
    logic quat_ready = 1'b0;
    quat_t quat;

    quat_scoreboard sb = new();
    longint cycles = 0;
    bit stall_mode = 1'b0;
    int sent = 0;

    always #1 clk = ~clk;

    rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat_ready  (mat_ready),
        .mat        (mat),
        .quat_valid (quat_valid),
        .quat_ready (quat_ready),
        .quat       (quat)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && quat_valid && quat_ready)
            sb.check_quat(quat);
        if (!rst_n)
            quat_ready <= 1'b0;
        else if (stall_mode)
            quat_ready <= ($urandom_range(0, 3) != 0);
        else
            quat_ready <= 1'b1;
    end

    always @(posedge clk)
        if (cycles % 500 == 0)
            stall_mode <= ($urandom_range(0, 2) != 0);

    task automatic send_matrix(mat_t m);
        mat_valid <= 1'b1;
        mat <= m;
        do
            @(posedge clk);
        while (!mat_ready);
        sb.note_matrix(m);
        sent++;
    endtask

    task automatic pause_sender(int n);
        mat_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic mat_t diag(int d0, int d1, int d2);
        mat_t m;
        m = '0;
        m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
        return m;
    endfunction

    // Builds a rotation from a random quaternion, optionally perturbing entries.
    function automatic mat_t random_rotation(int jitter);
        real w, x, y, z, n;
        real e[9];
        mat_t m;
        w = $urandom_range(0, 20000) - 10000.0;
        x = $urandom_range(0, 20000) - 10000.0;
        y = $urandom_range(0, 20000) - 10000.0;
        z = $urandom_range(0, 20000) - 10000.0;
        n = $sqrt(w * w + x * x + y * y + z * z) + 1.0e-9;
        w /= n; x /= n; y /= n; z /= n;
        e[0] = 1 - 2 * (y * y + z * z); e[1] = 2 * (x * y - w * z); e[2] = 2 * (x * z + w * y);
        e[3] = 2 * (x * y + w * z); e[4] = 1 - 2 * (x * x + z * z); e[5] = 2 * (y * z - w * x);
        e[6] = 2 * (x * z - w * y); e[7] = 2 * (y * z + w * x); e[8] = 1 - 2 * (x * x + y * y);
        for (int i = 0; i < 9; i++)
            m[(8 - i) * 16 +: 16] = 16'($rtoi(e[i] * ONE) + $urandom_range(0, 2 * jitter) - jitter);
        return m;
    endfunction

    function automatic mat_t random_bits();
        mat_t m;
        for (int i = 0; i < 9; i++)
            m[i * 16 +: 16] = 16'($urandom);
        return m;
    endfunction

    initial
    begin
        mat_t m;
        int burst;
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(ONE, -ONE, -ONE));
        send_matrix(diag(-ONE, ONE, -ONE));
        send_matrix(diag(-ONE, -ONE, ONE));
        send_matrix(diag(0, 0, 0));
        send_matrix(diag(-ONE, -ONE, -ONE));
        send_matrix(diag(32767, 32767, 32767));
        send_matrix(diag(-32768, -32768, -32768));
        send_matrix(diag(32767, -32768, -32768));
        send_matrix(diag(-32768, 32767, -32768));
        send_matrix(diag(-32768, -32768, 32767));
        m = '1;
        send_matrix(m);
        m = {9{16'h7fff}};
        send_matrix(m);
        m = {9{16'h8000}};
        send_matrix(m);
        m = {9{16'h5555}};
        send_matrix(m);
        m = {9{16'haaaa}};
        send_matrix(m);
        m = diag(0, 0, ONE);
        m.m01 = 16'(-ONE); m.m10 = 16'(ONE);
        send_matrix(m);
        m = diag(0, 0, ONE);
        m.m01 = 16'(ONE); m.m10 = 16'(-ONE);
        send_matrix(m);
        m = diag(-ONE, 0, 0);
        m.m12 = 16'(ONE); m.m21 = 16'(-ONE);
        send_matrix(m);
        m = diag(0, 0, 0);
        m.m02 = 16'(ONE); m.m20 = 16'(ONE); m.m12 = 16'(-ONE); m.m21 = 16'(-ONE);
        send_matrix(m);

        pause_sender(0);
        while (sb.expected_q.size() != 0)
            @(posedge clk);

        k = 0;
        while (k < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && k < N_RANDOM; j++, k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    send_matrix(random_bits());
                    2:       send_matrix(random_rotation(200));
                    default: send_matrix(random_rotation(0));
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        mat_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d matrices (directed corner cases, rotations, raw patterns).", sent);
        $display("Checked %0d quaternions under random source gaps and sink stalls.",
                 sb.checked);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
